@@ design/cannon_safety_fire_controller_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion helpers for the cannon safety and fire controller
// Same-cycle and next-cycle implication checks, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef CANNON_SAFETY_FIRE_CONTROLLER_ASSERT_SVH
`define CANNON_SAFETY_FIRE_CONTROLLER_ASSERT_SVH

// cons must hold in the same cycle as ante
`define CSFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define CSFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/csfc_pkg.sv @@
// ---------------------------------------------------------------------------
// csfc_pkg
// Types, codes and constants shared by the fire controller modules.
// ---------------------------------------------------------------------------
package csfc_pkg;

   typedef enum logic [2:0] {
      MODE_DISABLED  = 3'd0,
      MODE_ENABLED   = 3'd1,
      MODE_ADJUSTING = 3'd2,
      MODE_PRIMED    = 3'd3,
      MODE_FIRING    = 3'd4,
      MODE_OTHER     = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      LED_DISABLED = 3'd0,
      LED_ENABLED  = 3'd1,
      LED_PRIMED   = 3'd2,
      LED_OFF      = 3'd3,
      LED_ERROR    = 3'd4
   } led_type;

   // requested status codes in a command message
   localparam logic [7:0] CMD_DISABLE = 8'd1;
   localparam logic [7:0] CMD_ENABLE  = 8'd2;
   localparam logic [7:0] CMD_ADJUST  = 8'd3;
   localparam logic [7:0] CMD_PRIME   = 8'd4;
   localparam logic [7:0] CMD_FIRE    = 8'd5;

   // CSR indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_ALIVE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_FIRE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRE_PER    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FIRE    = 2'd3;

   // CSR reset values
   localparam logic [15:0] KEEP_ALIVE_RST = 16'd1000;
   localparam logic [9:0]  MIN_FIRE_RST   = 10'd100;
   localparam logic [6:0]  FIRE_PER_RST   = 7'd10;
   localparam logic [7:0]  MAX_FIRE_RST   = 8'd20;

   localparam logic [15:0] FIRE_DUR_RST   = 16'd100;
   localparam logic [8:0]  SEEN_NONE      = 9'd511;

   // servo mapping
   localparam logic [10:0] NEUTRAL_US       = 11'd1500;
   localparam int          SERVO_STEPS      = 64;
   localparam int          SERVO_SPAN_US    = 500;
   localparam int          SERVO_FULL_SPEED = 63;

   typedef logic [8:0] servo_tab_type [SERVO_STEPS];

   function automatic servo_tab_type build_servo_tab();
      servo_tab_type tab;
      for (int i = 0; i < SERVO_STEPS; i++) begin
         tab[i] = 9'((i * SERVO_SPAN_US) / SERVO_FULL_SPEED);
      end
      return tab;
   endfunction

   // speed * 500 / 63, truncated
   localparam servo_tab_type SERVO_TAB = build_servo_tab();

   typedef struct packed {
      logic [15:0] keep_alive_ms;
      logic [9:0]  min_fire_ms;
      logic [6:0]  fire_ms_per_unit;
      logic [7:0]  max_fire_code;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        msg_valid;
      logic        msg_ok;
      logic [7:0]  msg_status;
      logic [7:0]  msg_index;
      logic [7:0]  fire_code;
      logic [6:0]  left_code;
      logic [6:0]  right_code;
   } req_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  led_pattern;
      logic        solenoid_open;
      logic [10:0] left_pulse_us;
      logic [10:0] right_pulse_us;
   } rsp_type;

   function automatic mode_type status_to_mode(logic [7:0] status);
      mode_type m;
      case (status)
         CMD_DISABLE: m = MODE_DISABLED;
         CMD_ENABLE:  m = MODE_ENABLED;
         CMD_ADJUST:  m = MODE_ADJUSTING;
         CMD_PRIME:   m = MODE_PRIMED;
         CMD_FIRE:    m = MODE_FIRING;
         default:     m = MODE_OTHER;
      endcase
      return m;
   endfunction

   function automatic led_type status_to_led(logic [7:0] status);
      led_type l;
      case (status)
         CMD_DISABLE: l = LED_DISABLED;
         CMD_ENABLE:  l = LED_ENABLED;
         CMD_PRIME:   l = LED_PRIMED;
         default:     l = LED_OFF;
      endcase
      return l;
   endfunction

   // bit 6 reverse, bits 5..0 speed
   function automatic logic [10:0] drive_pulse(logic [6:0] code);
      logic [8:0] step_us;
      step_us = SERVO_TAB[code[5:0]];
      if (code[6]) begin
         return NEUTRAL_US - 11'(step_us);
      end
      return NEUTRAL_US + 11'(step_us);
   endfunction

endpackage

@@ design/csfc_req_if.sv @@
// ---------------------------------------------------------------------------
// csfc_req_if
// Tick request channel: valid/ready plus the tick and message fields.
// ---------------------------------------------------------------------------
interface csfc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        msg_valid;
   logic        msg_ok;
   logic [7:0]  msg_status;
   logic [7:0]  msg_index;
   logic [7:0]  fire_code;
   logic [6:0]  left_code;
   logic [6:0]  right_code;

   modport source (
      output valid, now_ms, msg_valid, msg_ok, msg_status, msg_index,
             fire_code, left_code, right_code,
      input  ready
   );

   modport sink (
      input  valid, now_ms, msg_valid, msg_ok, msg_status, msg_index,
             fire_code, left_code, right_code,
      output ready
   );
endinterface

@@ design/csfc_rsp_if.sv @@
// ---------------------------------------------------------------------------
// csfc_rsp_if
// Result channel: valid/ready plus mode, LED, solenoid and servo widths.
// ---------------------------------------------------------------------------
interface csfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [2:0]  led_pattern;
   logic        solenoid_open;
   logic [10:0] left_pulse_us;
   logic [10:0] right_pulse_us;

   modport source (
      output valid, mode, led_pattern, solenoid_open, left_pulse_us, right_pulse_us,
      input  ready
   );

   modport sink (
      input  valid, mode, led_pattern, solenoid_open, left_pulse_us, right_pulse_us,
      output ready
   );
endinterface

@@ design/csfc_csr.sv @@
// ---------------------------------------------------------------------------
// csfc_csr
// Configuration registers, written through a plain write port.
// ---------------------------------------------------------------------------
module csfc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [csfc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [csfc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output csfc_pkg::cfg_type                    cfg
);

   csfc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keep_alive_ms    <= csfc_pkg::KEEP_ALIVE_RST;
         cfg_ff.min_fire_ms      <= csfc_pkg::MIN_FIRE_RST;
         cfg_ff.fire_ms_per_unit <= csfc_pkg::FIRE_PER_RST;
         cfg_ff.max_fire_code    <= csfc_pkg::MAX_FIRE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            csfc_pkg::CSR_KEEP_ALIVE: cfg_ff.keep_alive_ms    <= csr_wdata[15:0];
            csfc_pkg::CSR_MIN_FIRE:   cfg_ff.min_fire_ms      <= csr_wdata[9:0];
            csfc_pkg::CSR_FIRE_PER:   cfg_ff.fire_ms_per_unit <= csr_wdata[6:0];
            csfc_pkg::CSR_MAX_FIRE:   cfg_ff.max_fire_code    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/csfc_tick.sv @@
// ---------------------------------------------------------------------------
// csfc_tick
// Per-tick mode, watchdog, solenoid pulse and servo logic with its state.
// ---------------------------------------------------------------------------
module csfc_tick (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,     // commit one tick
   input  csfc_pkg::req_type   item,
   input  csfc_pkg::cfg_type   cfg,
   output csfc_pkg::rsp_type   result
);

   csfc_pkg::mode_type cur_mode_ff, cur_mode_in;
   csfc_pkg::led_type  led_ff, led_in;
   logic [7:0]  held_index_ff, held_index_in;
   logic [8:0]  seen_index_ff, seen_index_in;
   logic [31:0] last_rx_ff, last_rx_in;
   logic [15:0] fire_dur_ff, fire_dur_in;
   logic [31:0] close_time_ff, close_time_in;
   logic        pulse_ff, pulse_in;
   logic        latch_ff, latch_in;
   logic [7:0]  held_fire_ff, held_fire_in;
   logic [6:0]  held_left_ff, held_left_in;
   logic [6:0]  held_right_ff, held_right_in;

   csfc_pkg::mode_type mode_msg, mode_live;
   logic        msg_good, msg_bad;
   logic        early_pulse, refresh;
   logic [31:0] elapsed;
   logic [14:0] prod;
   logic [15:0] dur_calc;
   logic        pulse_keep, latch_keep;

   always_comb begin
      msg_good = item.msg_valid && item.msg_ok;
      msg_bad  = item.msg_valid && !item.msg_ok;

      held_index_in = msg_good ? item.msg_index  : held_index_ff;
      held_fire_in  = msg_good ? item.fire_code  : held_fire_ff;
      held_left_in  = msg_good ? item.left_code  : held_left_ff;
      held_right_in = msg_good ? item.right_code : held_right_ff;

      if (msg_bad) begin
         mode_msg = csfc_pkg::MODE_DISABLED;
         led_in   = csfc_pkg::LED_ERROR;
      end else if (msg_good) begin
         mode_msg = csfc_pkg::status_to_mode(item.msg_status);
         led_in   = csfc_pkg::status_to_led(item.msg_status);
      end else begin
         mode_msg = cur_mode_ff;
         led_in   = led_ff;
      end

      // watchdog and shot-in-progress override, skipped while disabled
      early_pulse   = pulse_ff && (item.now_ms < close_time_ff);
      refresh       = (mode_msg != csfc_pkg::MODE_DISABLED) &&
                      ({1'b0, held_index_in} != seen_index_ff);
      seen_index_in = refresh ? {1'b0, held_index_in} : seen_index_ff;
      last_rx_in    = refresh ? item.now_ms : last_rx_ff;
      elapsed       = item.now_ms - last_rx_in;

      mode_live = mode_msg;
      if (mode_msg != csfc_pkg::MODE_DISABLED) begin
         if (early_pulse) begin
            mode_live = csfc_pkg::MODE_ADJUSTING;
         end
         if (elapsed > {16'd0, cfg.keep_alive_ms}) begin
            mode_live = csfc_pkg::MODE_DISABLED;
         end
      end

      // open time = base + code * per-unit; never exceeds 16 bits
      prod        = 15'(held_fire_in) * 15'(cfg.fire_ms_per_unit);
      dur_calc    = 16'(cfg.min_fire_ms) + 16'(prod);
      fire_dur_in = (held_fire_in <= cfg.max_fire_code) ? dur_calc : fire_dur_ff;

      if (mode_live != csfc_pkg::MODE_FIRING && mode_live != csfc_pkg::MODE_ADJUSTING) begin
         pulse_keep = 1'b0;
         latch_keep = 1'b0;
      end else begin
         pulse_keep = early_pulse;
         latch_keep = latch_ff;
      end

      cur_mode_in   = mode_live;
      close_time_in = close_time_ff;
      pulse_in      = pulse_keep;
      latch_in      = latch_keep;
      // one shot per firing request
      if (mode_live == csfc_pkg::MODE_FIRING && !latch_keep) begin
         cur_mode_in   = csfc_pkg::MODE_ADJUSTING;
         close_time_in = item.now_ms + {16'd0, fire_dur_in};
         pulse_in      = 1'b1;
         latch_in      = 1'b1;
      end

      result.mode          = cur_mode_in;
      result.led_pattern   = led_in;
      result.solenoid_open = pulse_in;
      if (mode_live == csfc_pkg::MODE_ENABLED) begin
         result.left_pulse_us  = csfc_pkg::drive_pulse(held_left_in);
         result.right_pulse_us = csfc_pkg::drive_pulse(held_right_in);
      end else begin
         result.left_pulse_us  = csfc_pkg::NEUTRAL_US;
         result.right_pulse_us = csfc_pkg::NEUTRAL_US;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mode_ff   <= csfc_pkg::MODE_DISABLED;
         led_ff        <= csfc_pkg::LED_DISABLED;
         held_index_ff <= 8'd0;
         seen_index_ff <= csfc_pkg::SEEN_NONE;
         last_rx_ff    <= 32'd0;
         fire_dur_ff   <= csfc_pkg::FIRE_DUR_RST;
         close_time_ff <= 32'd0;
         pulse_ff      <= 1'b0;
         latch_ff      <= 1'b0;
         held_fire_ff  <= 8'd0;
         held_left_ff  <= 7'd0;
         held_right_ff <= 7'd0;
      end else if (step) begin
         cur_mode_ff   <= cur_mode_in;
         led_ff        <= led_in;
         held_index_ff <= held_index_in;
         seen_index_ff <= seen_index_in;
         last_rx_ff    <= last_rx_in;
         fire_dur_ff   <= fire_dur_in;
         close_time_ff <= close_time_in;
         pulse_ff      <= pulse_in;
         latch_ff      <= latch_in;
         held_fire_ff  <= held_fire_in;
         held_left_ff  <= held_left_in;
         held_right_ff <= held_right_in;
      end
   end

endmodule

@@ design/cannon_safety_fire_controller.sv @@
// ---------------------------------------------------------------------------
// cannon_safety_fire_controller
// Safety mode, keep-alive watchdog, solenoid pulse and drive servo control.
// ---------------------------------------------------------------------------
// Usage:
//  - req_ch carries one request per update tick: the millisecond time and,
//    when msg_valid is set, a decoded command message (msg_ok flags a clean
//    decode). rsp_ch returns exactly one result per request, in order.
//  - csr_write_en/csr_index/csr_wdata write the four setup registers
//    (keep-alive, base fire time, fire time per unit, max fire code).
//    Write only while no request is in flight.
//  - A request is held in the input register at the accepting edge and its
//    result is written to the result register when that register is free;
//    rsp_ch.valid comes from the result register. Throughput: one request
//    per cycle while rsp_ch is not stalled; the tick state loop (mode,
//    watchdog, pulse timer) is computed combinationally from its state.
//  - A stalled rsp_ch holds its result; one more request may sit in the
//    input register behind it, after which req_ch.ready drops.
//  - Reset (synchronous, active high) empties both registers and returns
//    to disabled mode, disabled LED, solenoid closed, no index seen, setup
//    registers at their defaults.
// ---------------------------------------------------------------------------
`include "cannon_safety_fire_controller_assert.svh"

module cannon_safety_fire_controller (
   input  logic                                clock,
   input  logic                                reset,
   csfc_req_if.sink                            req_ch,
   csfc_rsp_if.source                          rsp_ch,
   input  logic                                csr_write_en,
   input  logic [csfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [csfc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   csfc_pkg::cfg_type cfg;
   csfc_pkg::req_type req_item;
   csfc_pkg::req_type s1_item_ff;
   csfc_pkg::rsp_type tick_result;
   csfc_pkg::rsp_type out_item_ff;

   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;     // result register can take a new result
   logic step;         // request moves from input register to result register
   logic req_fire;

   csfc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   assign req_item.now_ms     = req_ch.now_ms;
   assign req_item.msg_valid  = req_ch.msg_valid;
   assign req_item.msg_ok     = req_ch.msg_ok;
   assign req_item.msg_status = req_ch.msg_status;
   assign req_item.msg_index  = req_ch.msg_index;
   assign req_item.fire_code  = req_ch.fire_code;
   assign req_item.left_code  = req_ch.left_code;
   assign req_item.right_code = req_ch.right_code;

   // handshake: input register drains whenever the result register frees up
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign step         = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (step) begin
         out_item_ff <= tick_result;
      end
   end

   // all tick state lives here and advances only on step
   csfc_tick u_tick (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (tick_result)
   );

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.mode           = out_item_ff.mode;
   assign rsp_ch.led_pattern    = out_item_ff.led_pattern;
   assign rsp_ch.solenoid_open  = out_item_ff.solenoid_open;
   assign rsp_ch.left_pulse_us  = out_item_ff.left_pulse_us;
   assign rsp_ch.right_pulse_us = out_item_ff.right_pulse_us;

   // a committed tick shows up as a result in the next cycle
   `CSFC_ASSERT_NEXT(a_step_gives_rsp, clock, reset, step, rsp_ch.valid, "tick result lost")
   // a request accepted over a full input register must push the old one on
   `CSFC_ASSERT_NOW(a_no_overwrite, clock, reset, req_fire && s1_valid_ff, step, "input register overwritten")
   // solenoid only open during a shot
   `CSFC_ASSERT_NOW(a_sol_mode, clock, reset, rsp_ch.valid && rsp_ch.solenoid_open, (rsp_ch.mode == csfc_pkg::MODE_ADJUSTING) || (rsp_ch.mode == csfc_pkg::MODE_FIRING), "solenoid open outside a shot")
   // drives stay neutral unless enabled
   `CSFC_ASSERT_NOW(a_neutral, clock, reset, rsp_ch.valid && (rsp_ch.mode != csfc_pkg::MODE_ENABLED), (rsp_ch.left_pulse_us == csfc_pkg::NEUTRAL_US) && (rsp_ch.right_pulse_us == csfc_pkg::NEUTRAL_US), "drive not neutral")

endmodule
